// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the median position filter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GMPF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GMPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/gmpf_pkg.sv =====
// ----------------------------------------------------------------------------
// gmpf_pkg
// Types and constants shared by the median position filter modules.
// ----------------------------------------------------------------------------
package gmpf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CNT_W     = $clog2(SAMPLE_W);
  localparam int CFG_IDX_W = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GATE_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEVIATION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH      = 3'd5;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] RST_ACCEPT_LOW    = 16'd2000;
  localparam logic [SAMPLE_W-1:0] RST_ACCEPT_HIGH   = 16'd8000;
  localparam logic [SAMPLE_W-1:0] RST_MAX_DEVIATION = 16'd500;
  localparam logic [SAMPLE_W-1:0] RST_OUT_LOW       = 16'd2000;
  localparam logic [SAMPLE_W-1:0] RST_OUT_HIGH      = 16'd8000;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MED1  = 6'b000010,
    S_DIFF  = 6'b000100,
    S_WRITE = 6'b001000,
    S_MED2  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  // Sequencer strobes to each axis
  typedef struct packed {
    logic clear;
    logic load;
    logic init;
    logic step;
    logic diff;
    logic write;
  } axis_ctrl_t;

  // Gate configuration seen by each axis
  typedef struct packed {
    logic                gate_enable;
    logic [SAMPLE_W-1:0] accept_low;
    logic [SAMPLE_W-1:0] accept_high;
    logic [SAMPLE_W-1:0] max_deviation;
  } gate_cfg_t;

endpackage

// ===== design/gmpf_select.sv =====
// ----------------------------------------------------------------------------
// gmpf_select
// Bit-serial rank selector: finds the middle value, MSB first, one bit a cycle while step is high.
// ----------------------------------------------------------------------------
module gmpf_select #(
  parameter int DEPTH = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          init,
  input  logic                          step,
  input  logic [DEPTH-1:0]              bits,
  output logic [gmpf_pkg::SAMPLE_W-1:0] median
);

  localparam int KW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DEPTH-1:0] active;
  logic [KW-1:0]    rank;
  logic [CW-1:0]    zeros;
  logic             take_zero;

  // candidates still in the running with a 0 at the current bit
  always_comb begin
    zeros = '0;
    for (int i = 0; i < DEPTH; i++) begin
      zeros = zeros + CW'(active[i] & ~bits[i]);
    end
    take_zero = zeros > CW'(rank);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      rank   <= '0;
    end else if (init) begin
      active <= {DEPTH{1'b1}};
      rank   <= KW'(DEPTH / 2);
    end else if (step) begin
      if (take_zero) begin
        active <= active & ~bits;
      end else begin
        active <= active & bits;
        rank   <= rank - KW'(zeros);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      median <= {median[gmpf_pkg::SAMPLE_W-2:0], ~take_zero};
    end
  end

endmodule

// ===== design/gmpf_axis.sv =====
// ----------------------------------------------------------------------------
// gmpf_axis
// One axis: sample ring as rotating shift registers, gate logic, selector.
// ----------------------------------------------------------------------------
module gmpf_axis #(
  parameter int DEPTH = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gmpf_pkg::axis_ctrl_t          ctrl,
  input  gmpf_pkg::gate_cfg_t           cfg,
  input  logic [gmpf_pkg::SAMPLE_W-1:0] sample_in,
  output logic [gmpf_pkg::SAMPLE_W-1:0] median
);

  localparam int W  = gmpf_pkg::SAMPLE_W;
  localparam int PW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic [W-1:0]     ring [DEPTH];
  logic [PW-1:0]    pos;
  logic [FW-1:0]    fill;
  logic [W-1:0]     sample;
  logic [W-1:0]     dev;
  logic [DEPTH-1:0] msbs;
  logic [W:0]       v_minus_m;
  logic [W:0]       m_minus_v;
  logic             fill_ok;
  logic             dev_ok;
  logic             wr_en;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      msbs[i] = ring[i][W-1];
    end
  end

  assign v_minus_m = {1'b0, sample} - {1'b0, median};
  assign m_minus_v = {1'b0, median} - {1'b0, sample};

  // filling phase: strict window, count not yet saturated
  assign fill_ok = cfg.gate_enable && (fill < FW'(DEPTH)) &&
                   (sample > cfg.accept_low) && (sample < cfg.accept_high);
  // tracking phase: inclusive window and close to the current median
  assign dev_ok  = (sample >= cfg.accept_low) && (sample <= cfg.accept_high) &&
                   (dev <= cfg.max_deviation);
  assign wr_en   = !cfg.gate_enable || fill_ok || dev_ok;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sample <= sample_in;
    end
    if (ctrl.diff) begin
      dev <= v_minus_m[W] ? m_minus_v[W-1:0] : v_minus_m[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        ring[i] <= '0;
      end
      pos  <= '0;
      fill <= '0;
    end else if (ctrl.clear) begin
      for (int i = 0; i < DEPTH; i++) begin
        ring[i] <= '0;
      end
      pos  <= '0;
      fill <= '0;
    end else if (ctrl.step) begin
      // a full rotation through all W bits leaves every entry as it was
      for (int i = 0; i < DEPTH; i++) begin
        ring[i] <= {ring[i][W-2:0], ring[i][W-1]};
      end
    end else if (ctrl.write && wr_en) begin
      ring[pos] <= sample;
      pos       <= (pos == PW'(DEPTH - 1)) ? '0 : pos + 1'b1;
      if (fill_ok) begin
        fill <= fill + 1'b1;
      end
    end
  end

  gmpf_select #(
    .DEPTH (DEPTH)
  ) u_select (
    .clk    (clk),
    .rst    (rst),
    .init   (ctrl.init),
    .step   (ctrl.step),
    .bits   (msbs),
    .median (median)
  );

endmodule

// ===== design/gated_median_position_filter.sv =====
// ----------------------------------------------------------------------------
// gated_median_position_filter
// Median-of-ring x,y position filter with window and deviation gating.
// ----------------------------------------------------------------------------
// Sequence: an accepted word runs two bit-serial median passes (before and after
//   the ring write); m_tvalid rises when OUT loads the output register.
//   No new word is taken until the sequence returns to IDLE.
// Reset (rst, synchronous): rings, write positions and fill counts go to zero,
//   registers to their defaults, both channels idle.
// ----------------------------------------------------------------------------
module gated_median_position_filter #(
  parameter int RING_DEPTH = 11
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_wr_en,
  input  logic [gmpf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gmpf_pkg::SAMPLE_W-1:0]      cfg_wr_data,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [2*gmpf_pkg::SAMPLE_W-1:0]    s_tdata,  // x_sample, y_sample
  input  logic [0:0]                         s_tuser,  // clear_first
  // output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [2*gmpf_pkg::SAMPLE_W-1:0]    m_tdata,  // x_filtered, y_filtered
  output logic [0:0]                         m_tuser   // pair_valid
);

  localparam int W = gmpf_pkg::SAMPLE_W;

  gmpf_pkg::state_t    state, state_next;
  logic [gmpf_pkg::CNT_W-1:0] bit_cnt;
  gmpf_pkg::axis_ctrl_t ctrl;
  gmpf_pkg::gate_cfg_t  gate_cfg;
  logic [W-1:0]        out_low;
  logic [W-1:0]        out_high;
  logic [W-1:0]        x_median;
  logic [W-1:0]        y_median;
  logic                accept;
  logic                last_bit;
  logic                out_free;
  logic                pair_ok;

  // --------------------------------------------------------------------------
  // Configuration registers; writes to unused indexes fall through
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_cfg.gate_enable   <= 1'b0;
      gate_cfg.accept_low    <= gmpf_pkg::RST_ACCEPT_LOW;
      gate_cfg.accept_high   <= gmpf_pkg::RST_ACCEPT_HIGH;
      gate_cfg.max_deviation <= gmpf_pkg::RST_MAX_DEVIATION;
      out_low                <= gmpf_pkg::RST_OUT_LOW;
      out_high               <= gmpf_pkg::RST_OUT_HIGH;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        gmpf_pkg::REG_GATE_ENABLE:   gate_cfg.gate_enable   <= cfg_wr_data[0];
        gmpf_pkg::REG_ACCEPT_LOW:    gate_cfg.accept_low    <= cfg_wr_data;
        gmpf_pkg::REG_ACCEPT_HIGH:   gate_cfg.accept_high   <= cfg_wr_data;
        gmpf_pkg::REG_MAX_DEVIATION: gate_cfg.max_deviation <= cfg_wr_data;
        gmpf_pkg::REG_OUT_LOW:       out_low                <= cfg_wr_data;
        gmpf_pkg::REG_OUT_HIGH:      out_high               <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  //   IDLE  : take a word; optional clear; arm the selectors
  //   MED1  : bit-serial median of the ring before the write
  //   DIFF  : register |sample - median|
  //   WRITE : gated ring write; re-arm the selectors
  //   MED2  : bit-serial median of the updated ring
  //   OUT   : window check into the output register (waits if it is full)
  // --------------------------------------------------------------------------
  assign s_tready = (state == gmpf_pkg::S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign last_bit = (bit_cnt == gmpf_pkg::CNT_W'(W - 1));
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      gmpf_pkg::S_IDLE:  if (accept) state_next = gmpf_pkg::S_MED1;
      gmpf_pkg::S_MED1:  if (last_bit) state_next = gmpf_pkg::S_DIFF;
      gmpf_pkg::S_DIFF:  state_next = gmpf_pkg::S_WRITE;
      gmpf_pkg::S_WRITE: state_next = gmpf_pkg::S_MED2;
      gmpf_pkg::S_MED2:  if (last_bit) state_next = gmpf_pkg::S_OUT;
      gmpf_pkg::S_OUT:   if (out_free) state_next = gmpf_pkg::S_IDLE;
      default:           state_next = gmpf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.clear = accept && s_tuser[0];
    ctrl.load  = accept;
    ctrl.init  = accept || (state == gmpf_pkg::S_WRITE);
    ctrl.step  = (state == gmpf_pkg::S_MED1) || (state == gmpf_pkg::S_MED2);
    ctrl.diff  = (state == gmpf_pkg::S_DIFF);
    ctrl.write = (state == gmpf_pkg::S_WRITE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= gmpf_pkg::S_IDLE;
      bit_cnt <= '0;
    end else begin
      state <= state_next;
      // wraps back to zero after the last step of a pass
      if (ctrl.step) begin
        bit_cnt <= bit_cnt + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Axis units
  // --------------------------------------------------------------------------
  gmpf_axis #(
    .DEPTH (RING_DEPTH)
  ) u_axis_x (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (gate_cfg),
    .sample_in (s_tdata[W-1:0]),
    .median    (x_median)
  );

  gmpf_axis #(
    .DEPTH (RING_DEPTH)
  ) u_axis_y (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (gate_cfg),
    .sample_in (s_tdata[2*W-1:W]),
    .median    (y_median)
  );

  // --------------------------------------------------------------------------
  // Output register: both medians must sit in the output window
  // --------------------------------------------------------------------------
  assign pair_ok = (x_median >= out_low) && (x_median <= out_high) &&
                   (y_median >= out_low) && (y_median <= out_high);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == gmpf_pkg::S_OUT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == gmpf_pkg::S_OUT) && out_free) begin
      m_tdata <= pair_ok ? {y_median, x_median} : '0;
      m_tuser <= pair_ok;
    end
  end

endmodule

// ===== design/gmpf_check.sv =====
// ----------------------------------------------------------------------------
// gmpf_check
// Port-level checks for the median position filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gmpf_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // a held word stays offered
  `GMPF_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "output word dropped while stalled")

  // an invalid pair carries zero coordinates
  `GMPF_ASSERT_SAME(a_zero_invalid, clk, rst, m_tvalid && !m_tuser[0], m_tdata == 32'd0, "invalid pair with nonzero data")

  // one word in flight: input closes right after an accept
  `GMPF_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready, "input open while word in work")

  // a new result follows a cycle with the input side closed
  `GMPF_ASSERT_SAME(a_result_after_work, clk, rst, $rose(m_tvalid), !$past(s_tready), "result without work cycle")

endmodule

bind gated_median_position_filter gmpf_check u_gmpf_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
